// ===== hw/rtl/lfpd_pkg.sv =====
// Package for the PD line follower drive block.
// Holds field widths, command and register codes, duty constants and shared types.
// No dependencies.
package lfpd_pkg;

  // Default sizing of the sample path and of the fixed-point fraction.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;

  // Fixed field widths.
  localparam int CMD_W       = 2;
  localparam int DUTY_W      = 10;
  localparam int GAIN_P_W    = 16;
  localparam int GAIN_D_W    = 20;
  localparam int OFFSET_W    = 10;
  localparam int MASK_W      = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  // Duty limits and the spin used while calibrating.
  localparam int DUTY_MAX  = 1000;
  localparam int SPIN_DUTY = 200;

  // Mask value with all three sensors on the line.
  localparam logic [MASK_W-1:0] ALL_ON = 3'b111;

  // Commands carried with each sample set.
  typedef enum logic [CMD_W-1:0] {
    CMD_CONTROL   = 2'd0,
    CMD_CALIBRATE = 2'd1,
    CMD_FINISH    = 2'd2,
    CMD_START     = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_SPEED    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_LEFT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_CENTER = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_RIGHT  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STEER_LIMIT   = 3'd6;

  // Configuration register file.
  typedef struct packed {
    logic [DUTY_W-1:0]   base_speed;
    logic [GAIN_P_W-1:0] gain_p;
    logic [GAIN_D_W-1:0] gain_d;
    logic [OFFSET_W-1:0] offset_left;
    logic [OFFSET_W-1:0] offset_center;
    logic [OFFSET_W-1:0] offset_right;
    logic [DUTY_W-1:0]   steer_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    base_speed:    10'd600,
    gain_p:        16'd384,
    gain_d:        20'd76800,
    offset_left:   10'd0,
    offset_center: 10'd400,
    offset_right:  10'd800,
    steer_limit:   10'd1000
  };

  // One result item.
  typedef struct packed {
    logic [DUTY_W-1:0] left_reverse_duty;
    logic [DUTY_W-1:0] left_forward_duty;
    logic [DUTY_W-1:0] right_reverse_duty;
    logic [DUTY_W-1:0] right_forward_duty;
    logic [MASK_W-1:0] line_mask;
    logic              running;
  } res_t;

endpackage

// ===== hw/rtl/lfpd_in_if.sv =====
// Sample channel of the PD line follower drive: valid/ready plus command and samples.
// Depends on lfpd_pkg.
interface lfpd_in_if #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
);
  import lfpd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] center_sample;
  logic [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output cmd, output left_sample, output center_sample,
                  output right_sample, input ready);
  modport sink   (input valid, input cmd, input left_sample, input center_sample,
                  input right_sample, output ready);
endinterface

// ===== hw/rtl/lfpd_out_if.sv =====
// Drive channel of the PD line follower drive: valid/ready plus duties and status.
// Depends on lfpd_pkg.
interface lfpd_out_if;
  import lfpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] left_reverse_duty;
  logic [DUTY_W-1:0] left_forward_duty;
  logic [DUTY_W-1:0] right_reverse_duty;
  logic [DUTY_W-1:0] right_forward_duty;
  logic [MASK_W-1:0] line_mask;
  logic              running;

  modport source (output valid, output left_reverse_duty, output left_forward_duty,
                  output right_reverse_duty, output right_forward_duty,
                  output line_mask, output running, input ready);
  modport sink   (input valid, input left_reverse_duty, input left_forward_duty,
                  input right_reverse_duty, input right_forward_duty,
                  input line_mask, input running, output ready);
endinterface

// ===== hw/rtl/lfpd_core.sv =====
// Controller state and single-pass tick logic: calibration extremes, thresholds,
// PD steering law and H-bridge duty mapping. Depends on lfpd_pkg.
module lfpd_core #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lfpd_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  lfpd_pkg::cmd_t         cmd,
  input  logic [SAMPLE_BITS-1:0] left_sample,
  input  logic [SAMPLE_BITS-1:0] center_sample,
  input  logic [SAMPLE_BITS-1:0] right_sample,
  input  lfpd_pkg::cfg_t         cfg,
  output lfpd_pkg::res_t         res
);
  import lfpd_pkg::*;

  localparam int TH_W  = ((SAMPLE_BITS > OFFSET_W) ? SAMPLE_BITS : OFFSET_W) + 1;
  localparam int ERR_W = SAMPLE_BITS + 1;
  localparam int DIF_W = ERR_W + 1;
  localparam int PP_W  = GAIN_P_W + 1 + ERR_W;
  localparam int PD_W  = GAIN_D_W + 1 + DIF_W;
  localparam int SUM_W = PD_W + 1;
  localparam int LIM_W = DUTY_W + FRAC_BITS;
  localparam int CL_W  = LIM_W + 1;
  localparam int SP_W  = CL_W + 1;
  localparam int MAG_W = SP_W - FRAC_BITS;

  // Controller state.
  logic                    run_flag;
  logic signed [ERR_W-1:0] last_error;
  logic [SAMPLE_BITS-1:0]  seen_max [3];
  logic [SAMPLE_BITS-1:0]  seen_min [3];
  logic [TH_W-1:0]         threshold [3];
  logic [DUTY_W-1:0]       drive_duty [4];

  logic                    run_flag_next;
  logic signed [ERR_W-1:0] last_error_next;
  logic [SAMPLE_BITS-1:0]  seen_max_next [3];
  logic [SAMPLE_BITS-1:0]  seen_min_next [3];
  logic [TH_W-1:0]         threshold_next [3];
  logic [DUTY_W-1:0]       drive_duty_next [4];

  logic [SAMPLE_BITS-1:0]  smp [3];
  logic [OFFSET_W-1:0]     offs [3];
  logic [MASK_W-1:0]       mask;

  logic signed [ERR_W-1:0] err;
  logic signed [DIF_W-1:0] dif;
  logic signed [PP_W-1:0]  prod_p;
  logic signed [PD_W-1:0]  prod_d;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lim;
  logic signed [SUM_W-1:0] sum_cl;
  logic signed [SP_W-1:0]  base;
  logic signed [SP_W-1:0]  corr;
  logic signed [SP_W-1:0]  speed_left;
  logic signed [SP_W-1:0]  speed_right;
  logic [2*DUTY_W-1:0]     duty_left;
  logic [2*DUTY_W-1:0]     duty_right;

  // Maps a signed speed to {reverse, forward} duties, truncating toward zero.
  function automatic logic [2*DUTY_W-1:0] map_duty(input logic signed [SP_W-1:0] v);
    logic [SP_W-1:0]   a;
    logic [MAG_W-1:0]  m;
    logic [DUTY_W-1:0] d;
    a = v[SP_W-1] ? SP_W'(-v) : SP_W'(v);
    m = a[SP_W-1:FRAC_BITS];
    d = (m > MAG_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : m[DUTY_W-1:0];
    return v[SP_W-1] ? {d, {DUTY_W{1'b0}}} : {{DUTY_W{1'b0}}, d};
  endfunction

  // Channel order: left, center, right.
  assign smp[0]  = left_sample;
  assign smp[1]  = center_sample;
  assign smp[2]  = right_sample;
  assign offs[0] = cfg.offset_left;
  assign offs[1] = cfg.offset_center;
  assign offs[2] = cfg.offset_right;

  // Line mask against the thresholds held before this tick.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mask[2-i] = TH_W'(smp[i]) > threshold[i];
    end
  end

  // PD law: error, two parallel products, sum and symmetric clamp.
  assign err    = $signed({1'b0, right_sample}) - $signed({1'b0, left_sample});
  assign dif    = $signed({err[ERR_W-1], err}) - $signed({last_error[ERR_W-1], last_error});
  assign prod_p = $signed({1'b0, cfg.gain_p}) * err;
  assign prod_d = $signed({1'b0, cfg.gain_d}) * dif;
  assign sum    = $signed({{(SUM_W-PP_W){prod_p[PP_W-1]}}, prod_p})
                + $signed({prod_d[PD_W-1], prod_d});
  assign lim    = $signed({{(SUM_W-LIM_W){1'b0}}, cfg.steer_limit, {FRAC_BITS{1'b0}}});

  always_comb begin
    if (sum > lim) begin
      sum_cl = lim;
    end else if (sum < -lim) begin
      sum_cl = -lim;
    end else begin
      sum_cl = sum;
    end
  end

  // Speed mix around the base speed and duty mapping.
  assign base        = $signed({2'b00, cfg.base_speed, {FRAC_BITS{1'b0}}});
  assign corr        = $signed({sum_cl[CL_W-1], sum_cl[CL_W-1:0]});
  assign speed_left  = base - corr;
  assign speed_right = base + corr;
  assign duty_left   = map_duty(speed_left);
  assign duty_right  = map_duty(speed_right);

  // Next state per command.
  always_comb begin
    run_flag_next   = run_flag;
    last_error_next = last_error;
    seen_max_next   = seen_max;
    seen_min_next   = seen_min;
    threshold_next  = threshold;
    drive_duty_next = drive_duty;
    unique case (cmd)
      CMD_CONTROL: begin
        run_flag_next = run_flag && (mask != ALL_ON);
        if (run_flag_next) begin
          if (mask[1]) begin
            last_error_next    = err;
            drive_duty_next[0] = duty_left[2*DUTY_W-1:DUTY_W];
            drive_duty_next[1] = duty_left[DUTY_W-1:0];
            drive_duty_next[2] = duty_right[2*DUTY_W-1:DUTY_W];
            drive_duty_next[3] = duty_right[DUTY_W-1:0];
          end
        end else begin
          last_error_next = '0;
          for (int j = 0; j < 4; j++) begin
            drive_duty_next[j] = '0;
          end
        end
      end
      CMD_CALIBRATE: begin
        for (int i = 0; i < 3; i++) begin
          if (smp[i] > seen_max[i]) begin
            seen_max_next[i] = smp[i];
          end
          if (smp[i] < seen_min[i]) begin
            seen_min_next[i] = smp[i];
          end
        end
        drive_duty_next[0] = '0;
        drive_duty_next[1] = DUTY_W'(SPIN_DUTY);
        drive_duty_next[2] = DUTY_W'(SPIN_DUTY);
        drive_duty_next[3] = '0;
      end
      CMD_FINISH: begin
        for (int i = 0; i < 3; i++) begin
          threshold_next[i] = TH_W'(((SAMPLE_BITS+1)'(seen_min[i])
                                     + (SAMPLE_BITS+1)'(seen_max[i])) >> 1)
                            + TH_W'(offs[i]);
        end
        for (int j = 0; j < 4; j++) begin
          drive_duty_next[j] = '0;
        end
      end
      CMD_START: begin
        run_flag_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // State registers, updated when a tick passes through.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag   <= 1'b0;
      last_error <= '0;
      for (int i = 0; i < 3; i++) begin
        seen_max[i]  <= '0;
        seen_min[i]  <= '1;
        threshold[i] <= '0;
      end
      for (int j = 0; j < 4; j++) begin
        drive_duty[j] <= '0;
      end
    end else if (advance) begin
      run_flag   <= run_flag_next;
      last_error <= last_error_next;
      seen_max   <= seen_max_next;
      seen_min   <= seen_min_next;
      threshold  <= threshold_next;
      drive_duty <= drive_duty_next;
    end
  end

  // Result of this tick: state after the tick plus the mask.
  assign res.left_reverse_duty  = drive_duty_next[0];
  assign res.left_forward_duty  = drive_duty_next[1];
  assign res.right_reverse_duty = drive_duty_next[2];
  assign res.right_forward_duty = drive_duty_next[3];
  assign res.line_mask          = mask;
  assign res.running            = run_flag_next;

  // A start tick always leaves the loop enabled.
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    advance && (cmd == CMD_START) |=> run_flag)
    else $error("run flag not set after start");

  // After a calibration tick every channel has min not above max.
  a_cal_order: assert property (@(posedge clk) disable iff (rst)
    advance && (cmd == CMD_CALIBRATE) |=>
      (seen_min[0] <= seen_max[0]) && (seen_min[1] <= seen_max[1])
      && (seen_min[2] <= seen_max[2]))
    else $error("calibration extremes out of order");

  // A bridge never drives both directions at once.
  a_bridge_excl: assert property (@(posedge clk) disable iff (rst)
    ((drive_duty[0] == '0) || (drive_duty[1] == '0))
    && ((drive_duty[2] == '0) || (drive_duty[3] == '0)))
    else $error("bridge driven in both directions");

  // A stopped control tick leaves the motors off.
  a_stop_off: assert property (@(posedge clk) disable iff (rst)
    advance && (cmd == CMD_CONTROL) && !run_flag |=>
      (drive_duty[0] == '0) && (drive_duty[1] == '0)
      && (drive_duty[2] == '0) && (drive_duty[3] == '0) && (last_error == '0))
    else $error("drive not cleared while stopped");

endmodule

// ===== hw/rtl/line_follower_pd_drive.sv =====
// PD line follower drive, top level. Uses lfpd_pkg, lfpd_in_if, lfpd_out_if and lfpd_core.
// Holds the configuration registers, the input register and the result register.
//
// Each transfer on sample_in carries a command and three sensor samples and yields
// exactly one transfer on drive_out with the four bridge duties, the line mask and
// the run status. An item is captured in the input register, goes through the
// controller logic while it is held there, and its result is captured in the result
// register, from which it is offered on drive_out. One item is taken every cycle
// while the result register is free or drains: the whole tick, including the two
// gain multiplies of the PD law, runs in a single pass that also updates the
// controller state, so each tick sees the state left by the one before it.
// A full result register that is not taken stops the input register from advancing;
// the input still accepts one item while it is empty. Configuration writes take effect
// at once and are meant to be made while no item is in flight.
module line_follower_pd_drive #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lfpd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  lfpd_in_if.sink                             sample_in,
  lfpd_out_if.source                          drive_out,
  input  logic                                cfg_write,
  input  logic [lfpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lfpd_pkg::*;

  cfg_t                   cfg;
  logic                   s1_valid;
  cmd_t                   s1_cmd;
  logic [SAMPLE_BITS-1:0] s1_left;
  logic [SAMPLE_BITS-1:0] s1_center;
  logic [SAMPLE_BITS-1:0] s1_right;
  logic                   out_valid;
  res_t                   out_res;
  res_t                   core_res;
  logic                   advance;
  logic                   in_fire;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_SPEED:    cfg.base_speed    <= cfg_data[DUTY_W-1:0];
        REG_GAIN_P:        cfg.gain_p        <= cfg_data[GAIN_P_W-1:0];
        REG_GAIN_D:        cfg.gain_d        <= cfg_data[GAIN_D_W-1:0];
        REG_OFFSET_LEFT:   cfg.offset_left   <= cfg_data[OFFSET_W-1:0];
        REG_OFFSET_CENTER: cfg.offset_center <= cfg_data[OFFSET_W-1:0];
        REG_OFFSET_RIGHT:  cfg.offset_right  <= cfg_data[OFFSET_W-1:0];
        REG_STEER_LIMIT:   cfg.steer_limit   <= cfg_data[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input register moves on when the result register is free or drains.
  assign advance         = s1_valid && (!out_valid || drive_out.ready);
  assign sample_in.ready = !s1_valid || advance;
  assign in_fire         = sample_in.valid && sample_in.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd    <= cmd_t'(sample_in.cmd);
      s1_left   <= sample_in.left_sample;
      s1_center <= sample_in.center_sample;
      s1_right  <= sample_in.right_sample;
    end
  end

  // Controller state and tick logic.
  lfpd_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .cmd           (s1_cmd),
    .left_sample   (s1_left),
    .center_sample (s1_center),
    .right_sample  (s1_right),
    .cfg           (cfg),
    .res           (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (drive_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign drive_out.valid              = out_valid;
  assign drive_out.left_reverse_duty  = out_res.left_reverse_duty;
  assign drive_out.left_forward_duty  = out_res.left_forward_duty;
  assign drive_out.right_reverse_duty = out_res.right_reverse_duty;
  assign drive_out.right_forward_duty = out_res.right_forward_duty;
  assign drive_out.line_mask          = out_res.line_mask;
  assign drive_out.running            = out_res.running;

  // A held item is never overwritten while the result waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !drive_out.ready |-> !sample_in.ready)
    else $error("input register overwritten while stalled");

  // An empty input register always takes a new item.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> sample_in.ready)
    else $error("empty input register not ready");

  // Every item that enters the input register leaves it or is still held.
  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted item lost from input register");

endmodule

// ===== tb/line_follower_pd_drive_checker.sv =====
// Checker for the PD line follower drive: watches both channels and the register port,
// predicts every drive transfer and compares it field by field.
// Depends on lfpd_pkg, lfpd_in_if and lfpd_out_if.
module line_follower_pd_drive_checker
  import lfpd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  lfpd_in_if                     sample_in,
  lfpd_out_if                    drive_out,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int LEVEL_W = SAMPLE_BITS + 1;

  // Shadow copy of the registers and of the controller state.
  cfg_t                          regs;
  logic                          loop_on;
  logic signed [LEVEL_W-1:0]     prev_error;
  logic [SAMPLE_BITS-1:0]        low_seen   [3];
  logic [SAMPLE_BITS-1:0]        high_seen  [3];
  logic [LEVEL_W-1:0]            line_level [3];
  logic [DUTY_W-1:0]             duty_now   [4];

  // Drive results owed by the block, oldest first.
  res_t                          awaited_drive [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: drive mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // One signed speed in fixed point onto the two duties of a bridge.
  function automatic void split_speed(input longint speed, output logic [DUTY_W-1:0] rev,
                                      output logic [DUTY_W-1:0] fwd);
    longint mag;
    mag = ((speed < 0) ? -speed : speed) >>> FRAC_BITS;
    if (mag > DUTY_MAX)
      mag = DUTY_MAX;
    rev = (speed < 0) ? DUTY_W'(mag) : '0;
    fwd = (speed < 0) ? '0 : DUTY_W'(mag);
  endfunction

  // Advances the shadow state by one tick and returns the drive it leaves.
  function automatic res_t step_controller(input cmd_t op,
                                           input logic [SAMPLE_BITS-1:0] lft,
                                           input logic [SAMPLE_BITS-1:0] ctr,
                                           input logic [SAMPLE_BITS-1:0] rgt);
    logic [SAMPLE_BITS-1:0] smp  [3];
    logic [OFFSET_W-1:0]    offs [3];
    logic [MASK_W-1:0]      mask;
    longint                 err, pd_sum, lim, base;
    res_t                   r;
    smp[0]  = lft;
    smp[1]  = ctr;
    smp[2]  = rgt;
    offs[0] = regs.offset_left;
    offs[1] = regs.offset_center;
    offs[2] = regs.offset_right;

    // The mask always uses the levels from before this tick.
    mask = '0;
    for (int i = 0; i < 3; i++)
      mask = {mask[MASK_W-2:0], ({1'b0, smp[i]} > line_level[i])};

    case (op)
      CMD_CONTROL: begin
        if (mask == ALL_ON)
          loop_on = 1'b0;
        if (!loop_on) begin
          for (int i = 0; i < 4; i++)
            duty_now[i] = '0;
          prev_error = '0;
        end else if ({1'b0, ctr} > line_level[1]) begin
          // PD law on the right-minus-left error, clamped before mixing.
          err    = longint'(rgt) - longint'(lft);
          pd_sum = longint'(regs.gain_p) * err
                 + longint'(regs.gain_d) * (err - longint'(prev_error));
          lim    = longint'(regs.steer_limit) << FRAC_BITS;
          base   = longint'(regs.base_speed) << FRAC_BITS;
          if (pd_sum > lim)
            pd_sum = lim;
          else if (pd_sum < -lim)
            pd_sum = -lim;
          prev_error = LEVEL_W'(err);
          split_speed(base - pd_sum, duty_now[0], duty_now[1]);
          split_speed(base + pd_sum, duty_now[2], duty_now[3]);
        end
      end
      CMD_CALIBRATE: begin
        for (int i = 0; i < 3; i++) begin
          if (smp[i] > high_seen[i])
            high_seen[i] = smp[i];
          if (smp[i] < low_seen[i])
            low_seen[i] = smp[i];
        end
        duty_now[0] = '0;
        duty_now[1] = DUTY_W'(SPIN_DUTY);
        duty_now[2] = DUTY_W'(SPIN_DUTY);
        duty_now[3] = '0;
      end
      CMD_FINISH: begin
        for (int i = 0; i < 3; i++) begin
          line_level[i] = LEVEL_W'(({1'b0, low_seen[i]} + {1'b0, high_seen[i]}) >> 1)
                        + LEVEL_W'(offs[i]);
        end
        for (int i = 0; i < 4; i++)
          duty_now[i] = '0;
      end
      CMD_START: begin
        loop_on = 1'b1;
      end
      default: begin
      end
    endcase

    r.left_reverse_duty  = duty_now[0];
    r.left_forward_duty  = duty_now[1];
    r.right_reverse_duty = duty_now[2];
    r.right_forward_duty = duty_now[3];
    r.line_mask          = mask;
    r.running            = loop_on;
    return r;
  endfunction

  // Register writes, sample transfers and drive transfers, all seen at the clock edge.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      regs       = CFG_RESET;
      loop_on    = 1'b0;
      prev_error = '0;
      for (int i = 0; i < 3; i++) begin
        low_seen[i]   = '1;
        high_seen[i]  = '0;
        line_level[i] = '0;
      end
      for (int i = 0; i < 4; i++)
        duty_now[i] = '0;
      awaited_drive.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BASE_SPEED:    regs.base_speed    = cfg_data[DUTY_W-1:0];
          REG_GAIN_P:        regs.gain_p        = cfg_data[GAIN_P_W-1:0];
          REG_GAIN_D:        regs.gain_d        = cfg_data[GAIN_D_W-1:0];
          REG_OFFSET_LEFT:   regs.offset_left   = cfg_data[OFFSET_W-1:0];
          REG_OFFSET_CENTER: regs.offset_center = cfg_data[OFFSET_W-1:0];
          REG_OFFSET_RIGHT:  regs.offset_right  = cfg_data[OFFSET_W-1:0];
          REG_STEER_LIMIT:   regs.steer_limit   = cfg_data[DUTY_W-1:0];
          default: begin
          end
        endcase
      end

      if (sample_in.valid && sample_in.ready) begin
        awaited_drive.push_back(step_controller(cmd_t'(sample_in.cmd),
                                                sample_in.left_sample,
                                                sample_in.center_sample,
                                                sample_in.right_sample));
      end

      if (drive_out.valid && drive_out.ready) begin
        if (awaited_drive.size() == 0) begin
          report_mismatch("drive transfer with no sample transfer waiting for it");
        end else begin
          want = awaited_drive.pop_front();
          check_field("left_reverse_duty", drive_out.left_reverse_duty,
                      want.left_reverse_duty);
          check_field("left_forward_duty", drive_out.left_forward_duty,
                      want.left_forward_duty);
          check_field("right_reverse_duty", drive_out.right_reverse_duty,
                      want.right_reverse_duty);
          check_field("right_forward_duty", drive_out.right_forward_duty,
                      want.right_forward_duty);
          check_field("line_mask", drive_out.line_mask, want.line_mask);
          check_field("running", drive_out.running, want.running);
        end
      end
    end
    pending = awaited_drive.size();
  end

endmodule

// ===== tb/line_follower_pd_drive_test.sv =====
// Top of the PD line follower drive testbench: clock, reset, register settings and
// sample stimulus with random idling; the checker beside the block does the comparing.
// Depends on lfpd_pkg, lfpd_in_if, lfpd_out_if and line_follower_pd_drive_checker.
module line_follower_pd_drive_test;
  import lfpd_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int HOLD_CYCLES = 80;
  localparam int RUN_LIMIT   = 3_000_000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;
  int                     idle_pct;
  int                     stall_pct;
  bit                     hold_armed;
  bit                     hold_done;

  lfpd_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  lfpd_out_if                             drive_ch ();

  line_follower_pd_drive u_dut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_ch),
    .drive_out (drive_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_follower_pd_drive_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_ch),
    .drive_out  (drive_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("line_follower_pd_drive verification failed");
    $finish;
  end

  // Receiver: random stalls per phase, plus one long hold-off counted here.
  initial begin
    drive_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        drive_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      drive_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] any_sample();
    return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
  endfunction

  // Offers one tick, with random idle cycles ahead of it, and waits for its transfer.
  task automatic send_tick(input cmd_t op, input logic [SAMPLE_BITS-1:0] lft,
                           input logic [SAMPLE_BITS-1:0] ctr,
                           input logic [SAMPLE_BITS-1:0] rgt);
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.cmd           <= op;
    sample_ch.left_sample   <= lft;
    sample_ch.center_sample <= ctr;
    sample_ch.right_sample  <= rgt;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Holds one register write for a single cycle; the caller lowers the enable.
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    put_reg(REG_BASE_SPEED,    CFG_DATA_W'(s.base_speed));
    put_reg(REG_GAIN_P,        CFG_DATA_W'(s.gain_p));
    put_reg(REG_GAIN_D,        CFG_DATA_W'(s.gain_d));
    put_reg(REG_OFFSET_LEFT,   CFG_DATA_W'(s.offset_left));
    put_reg(REG_OFFSET_CENTER, CFG_DATA_W'(s.offset_center));
    put_reg(REG_OFFSET_RIGHT,  CFG_DATA_W'(s.offset_right));
    put_reg(REG_STEER_LIMIT,   CFG_DATA_W'(s.steer_limit));
    cfg_write <= 1'b0;
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.base_speed    = DUTY_W'($urandom_range(DUTY_MAX));
    s.gain_p        = GAIN_P_W'($urandom_range(2047));
    s.gain_d        = GAIN_D_W'($urandom_range(200000));
    s.offset_left   = OFFSET_W'($urandom);
    s.offset_center = OFFSET_W'($urandom);
    s.offset_right  = OFFSET_W'($urandom);
    s.steer_limit   = DUTY_W'($urandom_range(DUTY_MAX));
    return s;
  endfunction

  // Stops offering and waits until every result is back and the pipeline is quiet.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // A calibration run, finish and start, then mostly control ticks with some noise.
  task automatic run_phase(input int ticks);
    logic [SAMPLE_BITS-1:0] lft, rgt;
    int                     pick;
    repeat ($urandom_range(6, 2))
      send_tick(CMD_CALIBRATE, any_sample(), any_sample(), any_sample());
    send_tick(CMD_FINISH, any_sample(), any_sample(), any_sample());
    send_tick(CMD_START, any_sample(), any_sample(), any_sample());
    repeat (ticks) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        // Half the control ticks keep left and right close: they differ only in the low eight bits.
        lft = any_sample();
        rgt = ($urandom_range(1) == 1) ? any_sample() : lft ^ SAMPLE_BITS'($urandom_range(255));
        send_tick(CMD_CONTROL, lft, any_sample(), rgt);
      end else if (pick < 90) begin
        send_tick(CMD_START, any_sample(), any_sample(), any_sample());
      end else if (pick < 96) begin
        send_tick(CMD_CALIBRATE, any_sample(), any_sample(), any_sample());
      end else begin
        send_tick(CMD_FINISH, any_sample(), any_sample(), any_sample());
      end
    end
  endtask

  // Main sequence: directed ticks, then random phases under different settings.
  initial begin
    rst                     <= 1'b1;
    cfg_write               <= 1'b0;
    cfg_index               <= '0;
    cfg_data                <= '0;
    sample_ch.valid         <= 1'b0;
    sample_ch.cmd           <= CMD_CONTROL;
    sample_ch.left_sample   <= '0;
    sample_ch.center_sample <= '0;
    sample_ch.right_sample  <= '0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_armed = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Stopped after reset, levels at zero.
    send_tick(CMD_CONTROL, 0, 0, 0);
    send_tick(CMD_CONTROL, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    // Finish with no calibration before it uses the reset extremes.
    send_tick(CMD_FINISH, 0, 0, 0);
    send_tick(CMD_START, SAMPLE_MAX, 0, SAMPLE_MAX);
    // Full right and full left error clamp the correction both ways.
    send_tick(CMD_CONTROL, 0, SAMPLE_MAX, SAMPLE_MAX);
    send_tick(CMD_CONTROL, SAMPLE_MAX, SAMPLE_MAX, 0);
    send_tick(CMD_CONTROL, 2000, 3000, 2010);
    // Samples equal to their level do not count as on the line.
    send_tick(CMD_CONTROL, 2047, 2448, 2847);
    send_tick(CMD_CONTROL, 2047, 2447, 2847);
    // Every sensor just above its level stops the loop.
    send_tick(CMD_CONTROL, 2048, 2448, 2848);
    send_tick(CMD_START, 0, 0, 0);
    // Calibration spin while running, then the law on the old levels.
    send_tick(CMD_CALIBRATE, 0, 0, 0);
    send_tick(CMD_CONTROL, 1000, SAMPLE_MAX, 1200);
    send_tick(CMD_CALIBRATE, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_tick(CMD_CALIBRATE, 1234, 2345, 3456);
    send_tick(CMD_FINISH, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_tick(CMD_CONTROL, 0, SAMPLE_MAX, 4000);
    send_tick(CMD_CONTROL, 0, 0, 0);
    send_tick(CMD_CONTROL, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_tick(CMD_CONTROL, 5, 6, 7);
    run_phase(105);

    // Every register at its top value; sender idles often.
    drain();
    load_settings('1);
    idle_pct = 57;
    run_phase(105);

    // Every register at zero; receiver stalls often.
    drain();
    load_settings('0);
    idle_pct  = 0;
    stall_pct = 57;
    run_phase(100);

    // Random settings; light idling on both sides.
    drain();
    load_settings(random_settings());
    idle_pct  = 6;
    stall_pct = 6;
    run_phase(105);

    // Random settings; a long receiver hold-off fills the block while items keep coming.
    drain();
    load_settings(random_settings());
    idle_pct   = 0;
    stall_pct  = 0;
    hold_armed = 1'b1;
    run_phase(100);

    drain();
    if (fail_count == 0)
      $display("line_follower_pd_drive verification clean");
    else
      $display("line_follower_pd_drive verification failed");
    $finish;
  end

endmodule
